[hw/rtl/ibm_pkg.sv]
// Shared types and constants of the incremental bipartite matcher.
// Holds the item structs and the controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package ibm_pkg;

    // default graph size
    localparam int MAX_LEFT_DEF  = 16;
    localparam int MAX_RIGHT_DEF = 16;

    // item modes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] left_vertex;
        logic [7:0] right_vertex;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] match_count;
        logic       partner_valid;
        logic [3:0] partner_right;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       set_high;
        logic       dup_rd;
        logic       dup_mark;
        logic       append;
        logic       pair_direct;
        logic       lv_next;
        logic       start;
        logic       adv_rd;
        logic       pop;
        logic       push;
        logic       unw_rd;
        logic       unw_pair;
        logic       total_inc;
        logic       out_load;
        logic [1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic out_of_range;
        logic dup_more;
        logic dup_hit;
        logic dup_found;
        logic count_full;
        logic both_free;
        logic lv_end;
        logic lv_matched;
        logic top_exhausted;
        logic sp_one;
        logic r_free;
        logic can_push;
        logic out_busy;
    } t_sts;

endpackage

[hw/rtl/ibm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ibm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ibm_datapath.sv]
// Datapath of the matcher: neighbor memory, counts, partners, search stack, result register.
// Depends on ibm_pkg and ibm_ram.
`timescale 1ns / 1ps

module ibm_datapath #(
    parameter int MaxLeft  = ibm_pkg::MAX_LEFT_DEF,
    parameter int MaxRight = ibm_pkg::MAX_RIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ibm_pkg::t_in_item i_item,
    input  ibm_pkg::t_cmd     i_cmd,
    input  logic              i_stall,
    output ibm_pkg::t_sts     o_sts,
    output logic              o_valid,
    output ibm_pkg::t_out_item o_item
);
    import ibm_pkg::*;

    localparam int LW  = $clog2(MaxLeft);
    localparam int RW  = $clog2(MaxRight);
    localparam int CW  = $clog2(MaxRight + 1);
    localparam int SPW = $clog2(MaxLeft + 1);
    localparam int AW  = LW + RW;

    // latched item and scan state
    logic          r_mode;
    logic [7:0]    r_l;
    logic [7:0]    r_r;
    logic [CW-1:0] r_idx;
    logic          r_dup;
    logic [SPW-1:0] r_lv;
    logic [LW-1:0] r_high;
    logic [SPW-1:0] r_sp;
    logic [SPW-1:0] r_total;

    // per-vertex state
    logic [CW-1:0] r_cnt   [MaxLeft];
    logic [RW-1:0] r_lpart [MaxLeft];
    logic          r_lhas  [MaxLeft];
    logic [LW-1:0] r_rpart [MaxRight];
    logic          r_rhas  [MaxRight];
    logic          r_vis   [MaxLeft];
    logic [LW-1:0] r_stk_l [MaxLeft];
    logic [CW-1:0] r_stk_n [MaxLeft];

    logic      r_out_valid;
    t_out_item r_out;

    logic [LW-1:0]  l_idx;
    logic [RW-1:0]  r_i;
    logic [SPW-1:0] sp_m1;
    logic [LW-1:0]  top_i;
    logic [LW-1:0]  top_left;
    logic [CW-1:0]  top_next;
    logic [CW-1:0]  next_m1;
    logic [LW-1:0]  lv_i;
    logic [RW-1:0]  ram_rdata;
    logic [LW-1:0]  l2;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic           oor;

    assign l_idx    = r_l[LW-1:0];
    assign r_i      = r_r[RW-1:0];
    assign sp_m1    = r_sp - 1'b1;
    assign top_i    = sp_m1[LW-1:0];
    assign top_left = r_stk_l[top_i];
    assign top_next = r_stk_n[top_i];
    assign next_m1  = top_next - 1'b1;
    assign lv_i     = r_lv[LW-1:0];
    assign l2       = r_rpart[ram_rdata];
    assign oor      = (r_l >= 8'(MaxLeft)) || (r_mode == MODE_ADD && r_r >= 8'(MaxRight));

    // neighbor list memory, row per left vertex
    assign ram_we    = i_cmd.append;
    assign ram_waddr = {l_idx, r_cnt[l_idx][RW-1:0]};
    assign ram_re    = i_cmd.dup_rd | i_cmd.adv_rd | i_cmd.unw_rd;

    always_comb begin
        if (i_cmd.dup_rd) begin
            ram_raddr = {l_idx, r_idx[RW-1:0]};
        end else if (i_cmd.adv_rd) begin
            ram_raddr = {top_left, top_next[RW-1:0]};
        end else begin
            ram_raddr = {top_left, next_m1[RW-1:0]};
        end
    end

    ibm_ram #(
        .WIDTH (RW),
        .DEPTH (1 << AW)
    ) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_i),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // status toward the controller
    always_comb begin
        o_sts               = '0;
        o_sts.is_query      = (r_mode == MODE_QUERY);
        o_sts.out_of_range  = oor;
        o_sts.dup_more      = (r_idx < r_cnt[l_idx]);
        o_sts.dup_hit       = (ram_rdata == r_i);
        o_sts.dup_found     = r_dup;
        o_sts.count_full    = (r_cnt[l_idx] >= CW'(MaxRight));
        o_sts.both_free     = !r_lhas[l_idx] && !r_rhas[r_i];
        o_sts.lv_end        = (r_lv > SPW'(r_high));
        o_sts.lv_matched    = r_lhas[lv_i];
        o_sts.top_exhausted = (top_next >= r_cnt[top_left]);
        o_sts.sp_one        = (r_sp == SPW'(1));
        o_sts.r_free        = !r_rhas[ram_rdata];
        o_sts.can_push      = !r_vis[l2] && (r_sp < SPW'(MaxLeft));
        o_sts.out_busy      = r_out_valid && i_stall;
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high      <= '0;
            r_sp        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MaxLeft; i++) begin
                r_cnt[i]  <= '0;
                r_lhas[i] <= 1'b0;
                r_vis[i]  <= 1'b0;
            end
            for (int j = 0; j < MaxRight; j++) begin
                r_rhas[j] <= 1'b0;
            end
        end else begin
            if (i_cmd.set_high && l_idx > r_high) begin
                r_high <= l_idx;
            end
            if (i_cmd.append) begin
                r_cnt[l_idx] <= r_cnt[l_idx] + 1'b1;
            end
            if (i_cmd.pair_direct) begin
                r_lhas[l_idx] <= 1'b1;
                r_rhas[r_i]   <= 1'b1;
                r_total       <= r_total + 1'b1;
            end
            if (i_cmd.total_inc) begin
                r_total <= r_total + 1'b1;
            end
            // fresh search: clear marks, seed with the free left vertex
            if (i_cmd.start) begin
                for (int i = 0; i < MaxLeft; i++) begin
                    r_vis[i] <= 1'b0;
                end
                r_vis[lv_i] <= 1'b1;
                r_sp        <= SPW'(1);
            end
            if (i_cmd.pop) begin
                r_sp <= sp_m1;
            end
            if (i_cmd.push) begin
                r_vis[l2] <= 1'b1;
                r_sp      <= r_sp + 1'b1;
            end
            // unwind one frame along the augmenting path
            if (i_cmd.unw_pair) begin
                r_lhas[top_left]  <= 1'b1;
                r_rhas[ram_rdata] <= 1'b1;
                r_sp              <= sp_m1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_item.mode;
            r_l    <= i_item.left_vertex;
            r_r    <= i_item.right_vertex;
            r_idx  <= '0;
            r_dup  <= 1'b0;
            r_lv   <= '0;
        end
        if (i_cmd.dup_rd) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.dup_mark) begin
            r_dup <= 1'b1;
        end
        if (i_cmd.lv_next) begin
            r_lv <= r_lv + 1'b1;
        end
        if (i_cmd.pair_direct) begin
            r_lpart[l_idx] <= r_i;
            r_rpart[r_i]   <= l_idx;
        end
        if (i_cmd.start) begin
            r_stk_l[0] <= lv_i;
            r_stk_n[0] <= '0;
        end
        if (i_cmd.adv_rd) begin
            r_stk_n[top_i] <= top_next + 1'b1;
        end
        if (i_cmd.push) begin
            r_stk_l[r_sp[LW-1:0]] <= l2;
            r_stk_n[r_sp[LW-1:0]] <= '0;
        end
        if (i_cmd.unw_pair) begin
            r_lpart[top_left]  <= ram_rdata;
            r_rpart[ram_rdata] <= top_left;
        end
        if (i_cmd.out_load) begin
            r_out.status        <= i_cmd.status;
            r_out.match_count   <= 5'(r_total);
            r_out.partner_valid <= 1'b0;
            r_out.partner_right <= '0;
            if (r_mode == MODE_QUERY && i_cmd.status == ST_OK && r_lhas[l_idx]) begin
                r_out.partner_valid <= 1'b1;
                r_out.partner_right <= 4'(r_lpart[l_idx]);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // checks
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(MaxLeft))
        else $error("search stack overflow");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= SPW'(MaxLeft))
        else $error("pair total exceeds left vertex count");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && i_stall))
        else $error("result overwritten while stalled");
    a_unwind_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.unw_pair || i_cmd.adv_rd || i_cmd.pop) |-> r_sp != '0)
        else $error("stack access while empty");

endmodule

[hw/rtl/ibm_ctrl.sv]
// Controller state machine of the matcher: sequences duplicate check, append and search.
// Depends on ibm_pkg.
`timescale 1ns / 1ps

module ibm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ibm_pkg::t_sts i_sts,
    output logic          o_stall,
    output ibm_pkg::t_cmd o_cmd
);
    import ibm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DUP_RD, S_DUP_CHK, S_APPEND, S_SCAN,
        S_SRCH, S_EVAL, S_UNW_RD, S_UNW_WR, S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_stall, n_stall;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.out_of_range) begin
                    n_status = ST_RANGE;
                    n_state  = S_FINISH;
                end else if (i_sts.is_query) begin
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.set_high = 1'b1;
                    n_state        = S_DUP_RD;
                end
            end
            S_DUP_RD: begin
                if (i_sts.dup_more) begin
                    o_cmd.dup_rd = 1'b1;
                    n_state      = S_DUP_CHK;
                end else if (i_sts.dup_found || i_sts.count_full) begin
                    n_status = ST_DUP;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_DUP_CHK: begin
                o_cmd.dup_mark = i_sts.dup_hit;
                n_state        = S_DUP_RD;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_status     = ST_OK;
                if (i_sts.both_free) begin
                    o_cmd.pair_direct = 1'b1;
                    n_state           = S_FINISH;
                end else begin
                    n_state = S_SCAN;
                end
            end
            // walk the free left vertices in order
            S_SCAN: begin
                if (i_sts.lv_end) begin
                    n_state = S_FINISH;
                end else if (i_sts.lv_matched) begin
                    o_cmd.lv_next = 1'b1;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_sts.top_exhausted) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.sp_one) begin
                        o_cmd.lv_next = 1'b1;
                        n_state       = S_SCAN;
                    end
                end else begin
                    o_cmd.adv_rd = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.r_free) begin
                    n_state = S_UNW_RD;
                end else begin
                    o_cmd.push = i_sts.can_push;
                    n_state    = S_SRCH;
                end
            end
            S_UNW_RD: begin
                o_cmd.unw_rd = 1'b1;
                n_state      = S_UNW_WR;
            end
            S_UNW_WR: begin
                o_cmd.unw_pair = 1'b1;
                if (i_sts.sp_one) begin
                    o_cmd.total_inc = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    n_state = S_UNW_RD;
                end
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_stall  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_stall  <= n_stall;
        end
    end

    assign o_stall = r_stall;

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stall |-> r_state == S_IDLE)
        else $error("input open outside idle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !r_stall) |=> r_stall)
        else $error("stall not raised after accepting an item");
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_cmd.out_load)
        else $error("two results for one item");

endmodule

[hw/rtl/incremental_bipartite_matcher_unit.sv]
// Top level of the incremental bipartite matcher.
// Depends on ibm_pkg, ibm_ctrl, ibm_datapath (which holds ibm_ram).
`timescale 1ns / 1ps

// Keeps a maximum matching of a bipartite graph as edges are added, one item at a time.
// A query or an out-of-range item passes the check state and the finish state, which loads
// its result into the output register. An add first reads the left vertex's neighbor list
// entry by entry for the duplicate check, then appends the edge; a direct pairing ends there.
// Otherwise the augmenting search scans the free left vertices, examines their edges, pops
// exhausted frames and unwinds the found path. The pace of the search is set by the single
// read port of the neighbor memory, which every edge examination goes through. The next item
// is accepted the cycle after the previous one's result is loaded into the output register;
// a stalled result holds the block until it can be loaded.
module incremental_bipartite_matcher_unit #(
    parameter int MaxLeft  = ibm_pkg::MAX_LEFT_DEF,
    parameter int MaxRight = ibm_pkg::MAX_RIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ibm_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output ibm_pkg::t_out_item o_item
);
    import ibm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ibm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    ibm_datapath #(
        .MaxLeft  (MaxLeft),
        .MaxRight (MaxRight)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_stall (i_stall),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

[tb/sv/tb_top.sv]
// Testbench for the incremental bipartite matcher: a directed table, then random items.
// Results are checked against a behavioral matcher kept inside the bench or, for some directed rows, fixed values.
// Depends on ibm_pkg and incremental_bipartite_matcher_unit.
`timescale 1ns / 1ps

module tb_top;
    import ibm_pkg::*;

    localparam int NL = MAX_LEFT_DEF;
    localparam int NR = MAX_RIGHT_DEF;
    localparam int RANDOM_ITEMS = 850;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    incremental_bipartite_matcher_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // matcher state mirrored in the bench
    logic [3:0] adj [NL][NR];
    int         adj_cnt [NL];
    int         lmate [NL];
    int         rmate [NR];
    bit         seen [NL];
    int         pairs;
    int         top_left;

    t_out_item  pending_results [$];
    int         fail_count = 0;
    int         got_count = 0;
    int         add_count;
    int         query_count;

    function automatic void clear_graph();
        for (int i = 0; i < NL; i++) begin
            adj_cnt[i] = 0;
            lmate[i] = -1;
        end
        for (int i = 0; i < NR; i++) rmate[i] = -1;
        pairs = 0;
        top_left = 0;
    endfunction

    // depth-first augmenting path search with explicit frames
    function automatic bit augment(int start);
        int fl [NL];
        int fn [NL];
        int sp;
        int l;
        int r;
        int l2;
        for (int i = 0; i < NL; i++) seen[i] = 0;
        seen[start] = 1;
        fl[0] = start;
        fn[0] = 0;
        sp = 1;
        while (sp > 0) begin
            l = fl[sp-1];
            if (fn[sp-1] >= adj_cnt[l]) begin
                sp--;
                continue;
            end
            r = adj[l][fn[sp-1]];
            fn[sp-1]++;
            if (rmate[r] < 0) begin
                // flip the path: each frame takes the edge it last followed
                for (int k = sp; k > 0; k--) begin
                    r = adj[fl[k-1]][fn[k-1]-1];
                    lmate[fl[k-1]] = r;
                    rmate[r] = fl[k-1];
                end
                return 1;
            end
            l2 = rmate[r];
            if (seen[l2] || sp >= NL) continue;
            seen[l2] = 1;
            fl[sp] = l2;
            fn[sp] = 0;
            sp++;
        end
        return 0;
    endfunction

    function automatic t_out_item predict_match(t_in_item it);
        t_out_item res;
        int l;
        int r;
        bit dup;
        res = '0;
        l = it.left_vertex;
        r = it.right_vertex;
        if (it.mode == MODE_QUERY) begin
            if (l >= NL) res.status = ST_RANGE;
            else if (lmate[l] >= 0) begin
                res.partner_valid = 1'b1;
                res.partner_right = 4'(lmate[l]);
            end
        end else if (l >= NL || r >= NR) begin
            res.status = ST_RANGE;
        end else begin
            if (l > top_left) top_left = l;
            dup = 0;
            for (int i = 0; i < adj_cnt[l]; i++) if (adj[l][i] == 4'(r)) dup = 1;
            if (dup || adj_cnt[l] >= NR) begin
                res.status = ST_DUP;
            end else begin
                adj[l][adj_cnt[l]] = 4'(r);
                adj_cnt[l]++;
                if (lmate[l] < 0 && rmate[r] < 0) begin
                    lmate[l] = r;
                    rmate[r] = l;
                    pairs++;
                end else begin
                    for (int lv = 0; lv <= top_left; lv++) begin
                        if (lmate[lv] >= 0) continue;
                        if (augment(lv)) begin
                            pairs++;
                            break;
                        end
                    end
                end
            end
        end
        res.match_count = 5'(pairs);
        return res;
    endfunction

    // directed table: fixed expectations where obvious, else predictor
    typedef struct {
        t_in_item  it;
        bit        fixed;
        t_out_item res;
    } t_row;

    t_row directed [$];

    function automatic t_in_item mk(logic m, int l, int r);
        t_in_item it;
        it.mode = m;
        it.left_vertex = 8'(l);
        it.right_vertex = 8'(r);
        return it;
    endfunction

    function automatic t_out_item mkr(logic [1:0] st, int mc, bit pv, int pr);
        t_out_item o;
        o.status = st;
        o.match_count = 5'(mc);
        o.partner_valid = pv;
        o.partner_right = 4'(pr);
        return o;
    endfunction

    task automatic add_row(t_in_item it, bit fx, t_out_item o);
        t_row rw;
        rw.it = it;
        rw.fixed = fx;
        rw.res = o;
        directed.push_back(rw);
    endtask

    // sender: random gap with valid low, then hold the item until accepted
    task automatic send_item(t_in_item it);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_item  <= t_in_item'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    // random stimulus: mostly in-range adds, some queries and noise
    function automatic t_in_item rand_item(int lim);
        t_in_item it;
        int k;
        it = t_in_item'($urandom);
        k = $urandom_range(0, 99);
        if (k < 60) begin
            it.mode = MODE_ADD;
            it.left_vertex = 8'($urandom_range(0, lim - 1));
            it.right_vertex = 8'($urandom_range(0, lim - 1));
        end else if (k < 85) begin
            it.mode = MODE_QUERY;
            it.left_vertex = 8'($urandom_range(0, NL - 1));
        end
        return it;
    endfunction

    // receiver: random stall, compare with oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got_count++;
                if (pending_results.size() == 0) begin
                    $error("result with no expectation: %p", o_item);
                    fail_count++;
                end else begin
                    t_out_item e;
                    e = pending_results.pop_front();
                    if (o_item.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_item.status);
                        fail_count++;
                    end
                    if (o_item.match_count !== e.match_count) begin
                        $error("match_count exp %0d got %0d", e.match_count,
                               o_item.match_count);
                        fail_count++;
                    end
                    if (o_item.partner_valid !== e.partner_valid) begin
                        $error("partner_valid exp %0d got %0d", e.partner_valid,
                               o_item.partner_valid);
                        fail_count++;
                    end
                    if (o_item.partner_right !== e.partner_right) begin
                        $error("partner_right exp %0d got %0d", e.partner_right,
                               o_item.partner_right);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 49) == 0) i_stall <= 1'b1;
            else if (i_stall) i_stall <= ($urandom_range(0, 5) != 0);
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int lim;
        t_out_item p;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        add_count = 0;
        query_count = 0;
        clear_graph();

        // after reset, out-of-range ids, and the classic augmenting cases
        add_row(mk(MODE_QUERY, 0, 255), 1, mkr(ST_OK, 0, 0, 0));
        add_row(mk(MODE_QUERY, 255, 0), 1, mkr(ST_RANGE, 0, 0, 0));
        add_row(mk(MODE_QUERY, NL, 0), 1, mkr(ST_RANGE, 0, 0, 0));
        add_row(mk(MODE_ADD, 255, 0), 1, mkr(ST_RANGE, 0, 0, 0));
        add_row(mk(MODE_ADD, 0, 255), 1, mkr(ST_RANGE, 0, 0, 0));
        add_row(mk(MODE_ADD, NL, NR), 1, mkr(ST_RANGE, 0, 0, 0));
        add_row(mk(MODE_ADD, 0, 0), 1, mkr(ST_OK, 1, 0, 0));
        add_row(mk(MODE_ADD, 0, 0), 1, mkr(ST_DUP, 1, 0, 0));
        add_row(mk(MODE_QUERY, 0, 170), 1, mkr(ST_OK, 1, 1, 0));
        add_row(mk(MODE_ADD, 1, 0), 0, '0);
        add_row(mk(MODE_ADD, 0, 1), 0, '0);
        add_row(mk(MODE_QUERY, 0, 0), 0, '0);
        add_row(mk(MODE_QUERY, 1, 0), 0, '0);
        add_row(mk(MODE_ADD, NL - 1, NR - 1), 0, '0);
        add_row(mk(MODE_ADD, NL - 1, 1), 0, '0);
        add_row(mk(MODE_ADD, 2, NR - 1), 0, '0);
        add_row(mk(MODE_QUERY, NL - 1, 85), 0, '0);
        add_row(mk(MODE_ADD, 3, 1), 0, '0);
        add_row(mk(MODE_ADD, 3, 0), 0, '0);
        add_row(mk(MODE_QUERY, 2, 0), 0, '0);
        add_row(mk(MODE_QUERY, 3, 0), 0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            p = predict_match(directed[i].it);
            pending_results.push_back(directed[i].fixed ? directed[i].res : p);
            send_item(directed[i].it);
        end

        // random part; the id range widens and a neighbor list gets filled
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            t_in_item it;
            lim = (n < 300) ? 6 : (n < 550 ? 10 : NL);
            it = rand_item(lim);
            if (n >= 700 && n < 720) begin
                it.mode = MODE_ADD;
                it.left_vertex = 8'd5;
                it.right_vertex = 8'(n - 700);
            end
            if (it.mode == MODE_ADD) add_count++;
            else query_count++;
            pending_results.push_back(predict_match(it));
            send_item(it);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d directed items, %0d random adds and %0d queries",
                 directed.size(), add_count, query_count);
        $display("checked %0d results, final matching size %0d", got_count, pairs);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // timeout
    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
